// ===== sv/fpalu_pkg.sv =====
// package: types, constants and saturation helpers for the q24.8 fixed-point alu
package fpalu_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC_W = 8;
    localparam int NUM_W  = WORD_W + FRAC_W;
    localparam int MAG_W  = 2 * WORD_W + 1 - FRAC_W;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
        OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
        OP_INC = 4'd12, OP_DEC = 4'd13, OP_TO_INT = 4'd14, OP_FROM_INT = 4'd15
    } t_op;

    typedef struct packed {
        logic [3:0]               kind;
        logic signed [WORD_W-1:0] operand_a;
        logic signed [WORD_W-1:0] operand_b;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_W-1:0] result_value;
        logic                     compare_true;
        logic                     div_zero;
        logic                     saturated;
    } t_out_item;

    typedef struct packed {
        logic [3:0]               kind;
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] b;
        logic [2*WORD_W-1:0]      prod;
        logic [NUM_W-1:0]         num;
        logic [WORD_W-1:0]        den;
        logic [WORD_W:0]          rem;
        logic [NUM_W-1:0]         quo;
    } t_stage;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              sat;
    } t_sat;

    function automatic t_sat clamp_signed(input logic signed [WORD_W:0] v);
        t_sat r;
        r.sat   = v[WORD_W] != v[WORD_W-1];
        r.value = r.sat ? {v[WORD_W], {(WORD_W-1){~v[WORD_W]}}} : v[WORD_W-1:0];
        return r;
    endfunction

    function automatic t_sat clamp_mag(input logic neg, input logic [MAG_W-1:0] m);
        logic [MAG_W-1:0] lim;
        t_sat             r;
        lim   = {{(MAG_W-WORD_W){1'b0}}, 1'b1, {(WORD_W-1){1'b0}}} - {{(MAG_W-1){1'b0}}, ~neg};
        r.sat = m > lim;
        r.value = r.sat ? lim[WORD_W-1:0] : m[WORD_W-1:0];
        if (neg) begin
            r.value = -r.value;
        end
        return r;
    endfunction

endpackage

// ===== sv/fpalu_cell.sv =====
// one divider step cell: shifts a dividend bit into the remainder and carries the item
module fpalu_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  fpalu_pkg::t_stage   i_stage,
    output logic                o_valid,
    output fpalu_pkg::t_stage   o_stage
);
    import fpalu_pkg::*;

    logic            r_valid;
    t_stage          r_stage;
    t_stage          n_stage;
    logic [WORD_W:0] rem_sh;
    logic            ge;

    always_comb begin
        rem_sh        = {i_stage.rem[WORD_W-1:0], i_stage.num[NUM_W-1]};
        ge            = rem_sh >= {1'b0, i_stage.den};
        n_stage       = i_stage;
        n_stage.rem   = ge ? rem_sh - {1'b0, i_stage.den} : rem_sh;
        n_stage.num   = {i_stage.num[NUM_W-2:0], 1'b0};
        n_stage.quo   = {i_stage.quo[NUM_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;
endmodule

// ===== sv/fpalu_post.sv =====
// result stage: rounding, saturation and operation select
module fpalu_post (
    input  fpalu_pkg::t_stage    i_stage,
    output fpalu_pkg::t_out_item o_item
);
    import fpalu_pkg::*;

    logic signed [WORD_W:0] ax, bx;
    logic [2*WORD_W:0]      prod_r;
    logic [NUM_W:0]         quo_r;
    logic [WORD_W-1:0]      mag_a;
    logic                   neg_md, a_gt_b, rnd;
    t_sat                   s;

    always_comb begin
        ax     = {i_stage.a[WORD_W-1], i_stage.a};
        bx     = {i_stage.b[WORD_W-1], i_stage.b};
        neg_md = i_stage.a[WORD_W-1] ^ i_stage.b[WORD_W-1];
        a_gt_b = i_stage.a > i_stage.b;
        mag_a  = i_stage.a[WORD_W-1] ? -i_stage.a : i_stage.a;
        prod_r = {1'b0, i_stage.prod} + (2*WORD_W+1)'(1 << (FRAC_W-1));
        rnd    = {i_stage.rem, 1'b0} >= {2'b00, i_stage.den};
        quo_r  = {1'b0, i_stage.quo} + {{NUM_W{1'b0}}, rnd};
        s      = '0;
        o_item = '0;
        case (t_op'(i_stage.kind))
            OP_ADD: s = clamp_signed(ax + bx);
            OP_SUB: s = clamp_signed(ax - bx);
            OP_MUL: s = clamp_mag(neg_md, prod_r[2*WORD_W:FRAC_W]);
            OP_DIV: begin
                if (i_stage.b == '0) begin
                    o_item.div_zero = 1'b1;
                end else begin
                    s = clamp_mag(neg_md, {{(MAG_W-NUM_W-1){1'b0}}, quo_r});
                end
            end
            OP_GT: o_item.compare_true = a_gt_b;
            OP_LT: o_item.compare_true = i_stage.a < i_stage.b;
            OP_GE: o_item.compare_true = i_stage.a >= i_stage.b;
            OP_LE: o_item.compare_true = !a_gt_b;
            OP_EQ: o_item.compare_true = i_stage.a == i_stage.b;
            OP_NE: o_item.compare_true = i_stage.a != i_stage.b;
            OP_MIN: s.value = a_gt_b ? i_stage.b : i_stage.a;
            OP_MAX: s.value = a_gt_b ? i_stage.a : i_stage.b;
            OP_INC: s = clamp_signed(ax + (WORD_W+1)'(1));
            OP_DEC: s = clamp_signed(ax - (WORD_W+1)'(1));
            OP_TO_INT: s.value = i_stage.a >>> FRAC_W;
            default: s = clamp_mag(i_stage.a[WORD_W-1],
                                   {{(MAG_W-NUM_W){1'b0}}, mag_a, {FRAC_W{1'b0}}});
        endcase
        o_item.result_value = s.value;
        o_item.saturated    = s.sat;
    end
endmodule

// ===== sv/fixed_point_alu_top.sv =====
// top level: q24.8 fixed-point alu built as an input stage, a row of divider cells and a result stage
// pipeline from input accept to output valid: input stage, 40 divider step cells, output register
// throughput: one item per cycle unless the output stalls; the 40 divider step cells set the depth
// the multiplier sits between the input stage and the first cell
// the whole pipeline holds while the output register is full and not taken
// reset: synchronous active low, clears all valid bits; payload registers are not reset
module fixed_point_alu_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  fpalu_pkg::t_in_item    i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output fpalu_pkg::t_out_item   o_out_item
);
    import fpalu_pkg::*;

    logic      en;
    logic      r_s0_valid;
    t_stage    r_s0, n_s0, s0_mul;
    logic      cv [NUM_W+1];
    t_stage    cs [NUM_W+1];
    t_out_item post_item;
    logic      r_out_valid;
    t_out_item r_out;

    assign en = !r_out_valid || i_out_ready;

    always_comb begin
        n_s0      = '0;
        n_s0.kind = i_in_item.kind;
        n_s0.a    = i_in_item.operand_a;
        n_s0.b    = i_in_item.operand_b;
        n_s0.num  = {i_in_item.operand_a[WORD_W-1] ? -i_in_item.operand_a
                                                    : i_in_item.operand_a, {FRAC_W{1'b0}}};
        n_s0.den  = i_in_item.operand_b[WORD_W-1] ? -i_in_item.operand_b
                                                   : i_in_item.operand_b;
        s0_mul      = r_s0;
        s0_mul.prod = r_s0.num[NUM_W-1:FRAC_W] * r_s0.den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid  <= i_in_valid;
            r_out_valid <= cv[NUM_W];
        end
        if (en) begin
            r_s0  <= n_s0;
            r_out <= post_item;
        end
    end

    assign cv[0] = r_s0_valid;
    assign cs[0] = s0_mul;

    for (genvar g = 0; g < NUM_W; g++) begin : g_cell
        fpalu_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (cv[g]),
            .i_stage (cs[g]),
            .o_valid (cv[g+1]),
            .o_stage (cs[g+1])
        );
    end

    fpalu_post u_post (
        .i_stage (cs[NUM_W]),
        .o_item  (post_item)
    );

    assign o_in_ready  = en;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
endmodule

// ===== sv/fpalu_checker.sv =====
// port checker for the fixed-point alu and its bind
module fpalu_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input fpalu_pkg::t_out_item o_out_item
);
    import fpalu_pkg::*;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output item changed while stalled");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output slot");

    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.compare_true |-> o_out_item.result_value == '0)
        else $error("comparison with nonzero value");

    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.div_zero |->
            !o_out_item.saturated && o_out_item.result_value == '0)
        else $error("divide by zero with value or saturation");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.saturated |->
            o_out_item.result_value[WORD_W-2:0] == {(WORD_W-1){~o_out_item.result_value[WORD_W-1]}})
        else $error("saturated value is not a range bound");
endmodule

bind fixed_point_alu_top fpalu_checker u_fpalu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
